/* src/h4fd_pkg.sv */
// Shared types, constants and helpers for the H4 frame delimiter.
`default_nettype none

package h4fd_pkg;

  localparam int unsigned FRAME_MAX_DEF = 264;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OFF_W   = 9;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned HDR_W   = 3;

  localparam logic [BYTE_W-1:0] KIND_CMD = 8'h01;
  localparam logic [BYTE_W-1:0] KIND_ACL = 8'h02;
  localparam logic [BYTE_W-1:0] KIND_SCO = 8'h03;
  localparam logic [BYTE_W-1:0] KIND_EVT = 8'h04;
  localparam logic [BYTE_W-1:0] KIND_ISO = 8'h05;

  localparam logic [15:0] ISO_LEN_MASK = 16'h3fff;

  // Offset of the low length byte in a two-byte length header.
  localparam logic [OFF_W-1:0] LEN_LOW_OFF = 9'd3;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0]   bytes_held;
    logic [KIND_W-1:0]  packet_kind;
    logic [BYTE_W-1:0]  length_low_byte;
    logic [TOTAL_W-1:0] expected_total;
    logic               total_known;
  } frame_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_out;
    logic [OFF_W-1:0]   byte_offset;
    status_t            status;
    logic [TOTAL_W-1:0] frame_total;
  } frame_result_t;

  // Header bytes that follow the type byte; zero marks an unknown type.
  function automatic logic [HDR_W-1:0] hdr_size(input logic [BYTE_W-1:0] kind);
    logic [HDR_W-1:0] size;
    case (kind)
      KIND_CMD: size = 3'd3;
      KIND_ACL: size = 3'd4;
      KIND_SCO: size = 3'd3;
      KIND_EVT: size = 3'd2;
      KIND_ISO: size = 3'd4;
      default:  size = 3'd0;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

/* src/h4fd_core.sv */
// Per-byte deframing logic: result and next frame state for one byte.
`default_nettype none

module h4fd_core
  import h4fd_pkg::*;
#(
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic [BYTE_W-1:0] data_byte,
  input  frame_state_t      st,
  output frame_result_t     res,
  output frame_state_t      st_nxt
);

  logic [OFF_W-1:0]   off;
  logic [HDR_W-1:0]   b_hdr;
  logic [HDR_W-1:0]   hdr;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  low;
  logic [TOTAL_W-1:0] exp_total;
  logic               known;
  logic               wide_len;
  logic [15:0]        plen;
  logic [OFF_W-1:0]   held;

  always_comb begin
    off       = st.bytes_held;
    b_hdr     = hdr_size(data_byte);
    st_nxt    = st;
    res.byte_out    = data_byte;
    res.byte_offset = off;
    res.status      = ST_PENDING;
    res.frame_total = '0;
    kind      = st.packet_kind;
    hdr       = hdr_size({{(BYTE_W-KIND_W){1'b0}}, st.packet_kind});
    low       = st.length_low_byte;
    exp_total = st.expected_total;
    known     = st.total_known;
    wide_len  = 1'b0;
    plen      = '0;
    held      = '0;

    if (off >= OFF_W'(FRAME_MAX)) begin
      st_nxt     = '0;
      res.status = ST_OVERSIZE;
    end else if (off == '0 && b_hdr == '0) begin
      res.status = ST_UNKNOWN;
    end else begin
      // The type byte opens a fresh frame.
      if (off == '0) begin
        kind      = data_byte[KIND_W-1:0];
        hdr       = b_hdr;
        low       = '0;
        exp_total = '0;
        known     = 1'b0;
      end
      wide_len = (kind == KIND_ACL[KIND_W-1:0]) || (kind == KIND_ISO[KIND_W-1:0]);
      if (off == LEN_LOW_OFF && wide_len) begin
        low = data_byte;
      end
      if (off != '0 && off == {{(OFF_W-HDR_W){1'b0}}, hdr}) begin
        if (kind == KIND_ACL[KIND_W-1:0]) begin
          plen = {data_byte, low};
        end else if (kind == KIND_ISO[KIND_W-1:0]) begin
          plen = {data_byte, low} & ISO_LEN_MASK;
        end else begin
          plen = {8'd0, data_byte};
        end
        exp_total = TOTAL_W'(1) + TOTAL_W'(hdr) + TOTAL_W'(plen);
        known     = 1'b1;
      end
      held = off + OFF_W'(1);
      if (known && TOTAL_W'(held) >= exp_total) begin
        res.status      = ST_COMPLETE;
        res.frame_total = exp_total;
        st_nxt          = '0;
      end else begin
        st_nxt.bytes_held      = held;
        st_nxt.packet_kind     = kind;
        st_nxt.length_low_byte = low;
        st_nxt.expected_total  = exp_total;
        st_nxt.total_known     = known;
      end
    end
  end

endmodule

`default_nettype wire

/* src/h4_frame_delimiter.sv */
// Top level of the H4 frame delimiter: input register, deframer, result register.
// A byte taken passes through the input register and then the result register to the result port.
// Throughput: one byte per cycle; the input stalls only while both registers hold a byte
// and the waiting result is itself stalled.
// The frame state is updated in the same cycle the input register hands over a byte.
// Reset (rst_n low, synchronous) empties both registers and clears the frame state.
`default_nettype none

module h4_frame_delimiter
  import h4fd_pkg::*;
#(
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_byte_out,
  output logic [OFF_W-1:0]   out_byte_offset,
  output logic [1:0]         out_status,
  output logic [TOTAL_W-1:0] out_frame_total
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              res_valid_r;
  frame_result_t     res_r;
  frame_result_t     res_nxt;
  frame_state_t      st_r;
  frame_state_t      st_nxt;
  logic              advance;

  // The input register moves on whenever the result register is free or drains now.
  assign advance  = s1_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  h4fd_core #(
    .FRAME_MAX(FRAME_MAX)
  ) u_core (
    .data_byte(s1_data_r),
    .st       (st_r),
    .res      (res_nxt),
    .st_nxt   (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_byte_out    = res_r.byte_out;
  assign out_byte_offset = res_r.byte_offset;
  assign out_status      = res_r.status;
  assign out_frame_total = res_r.frame_total;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_held <= OFF_W'(FRAME_MAX))
    else $error("frame byte count above the frame limit");

  a_total_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.total_known |-> st_r.expected_total == '0)
    else $error("expected total set before the header is complete");

  a_total_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.status != ST_COMPLETE |-> res_r.frame_total == '0)
    else $error("frame total on a result that does not end a frame");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.status == ST_COMPLETE || res_nxt.status == ST_OVERSIZE)
    |=> st_r.bytes_held == '0)
    else $error("frame state not cleared after a frame ended");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && res_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

/* test/h4_frame_delimiter_test.sv */
// Self-checking testbench for the H4 frame delimiter: directed and random byte streams.
`timescale 1ns / 100ps

module h4_frame_delimiter_test;
  import h4fd_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned STIM_ITEMS  = 800;
  localparam int unsigned DRAIN_CYC   = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_byte_out;
  logic [OFF_W-1:0]   out_byte_offset;
  logic [1:0]         out_status;
  logic [TOTAL_W-1:0] out_frame_total;

  // Bytes waiting to be sent and tagged bytes waiting to come back.
  logic [BYTE_W-1:0] stream_q[$];
  frame_result_t     deframed_q[$];

  int unsigned stim_total   = 0;
  int unsigned bytes_taken  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Deframer state as seen by the predictor.
  logic [OFF_W-1:0]   held_cnt    = '0;
  logic [BYTE_W-1:0]  cur_kind    = '0;
  logic [BYTE_W-1:0]  len_low     = '0;
  logic [TOTAL_W-1:0] want_total  = '0;
  logic               total_valid = 1'b0;

  h4_frame_delimiter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_out    (out_byte_out),
    .out_byte_offset (out_byte_offset),
    .out_status      (out_status),
    .out_frame_total (out_frame_total)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver idles more in the first third, the sender in the second, nobody in the last.
  always_comb begin
    if (bytes_taken < stim_total / 3) begin
      send_idle_pct = 33;
      recv_idle_pct = 66;
    end else if (bytes_taken < 2 * stim_total / 3) begin
      send_idle_pct = 66;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic int unsigned header_bytes(input logic [BYTE_W-1:0] kind);
    case (kind)
      KIND_CMD: return 3;
      KIND_ACL: return 4;
      KIND_SCO: return 3;
      KIND_EVT: return 2;
      KIND_ISO: return 4;
      default:  return 0;
    endcase
  endfunction

  task automatic clear_frame();
    held_cnt    = '0;
    cur_kind    = '0;
    len_low     = '0;
    want_total  = '0;
    total_valid = 1'b0;
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output frame_result_t res);
    logic [OFF_W-1:0] off;
    int unsigned      hdr;
    logic [15:0]      plen;
    off             = held_cnt;
    res.byte_out    = b;
    res.byte_offset = off;
    res.status      = ST_PENDING;
    res.frame_total = '0;
    if (off >= FRAME_MAX_DEF) begin
      clear_frame();
      res.status = ST_OVERSIZE;
    end else if (off == 0 && header_bytes(b) == 0) begin
      res.status = ST_UNKNOWN;
    end else begin
      if (off == 0) begin
        cur_kind    = b;
        total_valid = 1'b0;
        want_total  = '0;
        len_low     = '0;
      end
      hdr = header_bytes(cur_kind);
      if (off == LEN_LOW_OFF && (cur_kind == KIND_ACL || cur_kind == KIND_ISO)) begin
        len_low = b;
      end
      if (off != 0 && off == hdr) begin
        if (cur_kind == KIND_ACL) begin
          plen = {b, len_low};
        end else if (cur_kind == KIND_ISO) begin
          plen = {b, len_low} & ISO_LEN_MASK;
        end else begin
          plen = {8'h00, b};
        end
        want_total  = TOTAL_W'(1 + hdr) + TOTAL_W'(plen);
        total_valid = 1'b1;
      end
      held_cnt = off + 1'b1;
      if (total_valid && TOTAL_W'(held_cnt) >= want_total) begin
        res.status      = ST_COMPLETE;
        res.frame_total = want_total;
        clear_frame();
      end
    end
  endtask

  // Queues one frame; payload stops one byte past the size limit, where the block drops it.
  task automatic add_frame(input logic [BYTE_W-1:0] kind, input logic [15:0] len_field);
    int unsigned hdr;
    int unsigned plen;
    int unsigned total;
    int unsigned k;
    bit          two_byte;
    hdr      = header_bytes(kind);
    two_byte = (kind == KIND_ACL || kind == KIND_ISO);
    stream_q.push_back(kind);
    for (k = 0; k < hdr - (two_byte ? 2 : 1); k++) begin
      stream_q.push_back(BYTE_W'($urandom));
    end
    if (two_byte) begin
      stream_q.push_back(len_field[7:0]);
      stream_q.push_back(len_field[15:8]);
      plen = (kind == KIND_ISO) ? (len_field & ISO_LEN_MASK) : len_field;
    end else begin
      stream_q.push_back(len_field[7:0]);
      plen = len_field[7:0];
    end
    total = 1 + hdr + plen;
    if (total > FRAME_MAX_DEF + 1) begin
      total = FRAME_MAX_DEF + 1;
    end
    for (k = 1 + hdr; k < total; k++) begin
      stream_q.push_back(BYTE_W'($urandom));
    end
  endtask

  always @(posedge clk) begin : driver
    frame_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte, res);
        deframed_q.push_back(res);
        bytes_taken = bytes_taken + 1;
      end
      // A stalled transfer keeps its byte; otherwise offer the next one or idle.
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("unexpected transfer: byte %02h offset %0d status %0d total %0d",
                     out_byte_out, out_byte_offset, out_status, out_frame_total);
          end
        end else begin
          want = deframed_q.pop_front();
          if (out_byte_out !== want.byte_out || out_byte_offset !== want.byte_offset ||
              out_status !== want.status || out_frame_total !== want.frame_total) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("mismatch: expected byte %02h offset %0d status %0d total %0d",
                       want.byte_out, want.byte_offset, want.status, want.frame_total);
              $display("          got      byte %02h offset %0d status %0d total %0d",
                       out_byte_out, out_byte_offset, out_status, out_frame_total);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("h4_frame_delimiter verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned k;
    logic [BYTE_W-1:0] kind;
    logic [15:0]       len_field;

    // Unknown types at both ends of the byte range and just past the last known type.
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hff);
    stream_q.push_back(KIND_ISO + 1'b1);
    // Every packet type with an empty or one-byte payload; the ISO length sets only bits outside the mask.
    add_frame(KIND_CMD, 16'd0);
    add_frame(KIND_ACL, 16'd0);
    add_frame(KIND_SCO, 16'd1);
    add_frame(KIND_EVT, 16'd0);
    add_frame(KIND_ISO, 16'hc000);

    // The largest frame that fits, then one whose ISO length survives masking but is too long.
    add_frame(KIND_ACL, 16'(FRAME_MAX_DEF - 5));
    add_frame(KIND_ISO, 16'hffff);

    while (stream_q.size() < STIM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        stream_q.push_back($urandom_range(1) ? 8'h00 :
                           BYTE_W'($urandom_range(KIND_ISO + 1, 255)));
      end else if (pick < 15) begin
        // Raw noise; it may start a frame that swallows the frames queued after it.
        for (k = 0; k < $urandom_range(1, 4); k++) begin
          stream_q.push_back(BYTE_W'($urandom));
        end
      end else begin
        kind = BYTE_W'($urandom_range(KIND_CMD, KIND_ISO));
        if ($urandom_range(24) == 0 && kind != KIND_ACL && kind != KIND_ISO) begin
          len_field = 16'($urandom_range(255));
        end else begin
          len_field = 16'($urandom_range(12));
        end
        if (kind == KIND_ISO) begin
          len_field[15:14] = 2'($urandom_range(3));
        end
        add_frame(kind, len_field);
      end
    end
    stim_total = stream_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < stim_total || deframed_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("h4_frame_delimiter verification clean");
    end else begin
      $display("h4_frame_delimiter verification failed");
    end
    $finish;
  end

endmodule
